@@ design/ye2je_pkg.sv @@
// shared types, codes and character tables for the yaml to json escape converter
package ye2je_pkg;

   // input transaction payload
   typedef struct packed {
      logic [7:0] in_byte;
      logic       input_end;
   } req_type;

   // result transaction payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic [1:0] error_code;
   } rsp_type;

   // error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_BAD_TYPE     = 2'd1;
   localparam logic [1:0] ERR_END_OF_INPUT = 2'd2;

   // characters used in the emitted text
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   // escape types emitted as themselves
   localparam logic [7:0] TYPE_QUOTE     = 8'h22;
   localparam logic [7:0] TYPE_SLASH     = 8'h2F;
   localparam logic [7:0] TYPE_SPACE     = 8'h20;

   // escape types emitted as backslash plus the type
   localparam logic [7:0] TYPE_BACKSLASH = 8'h5C;
   localparam logic [7:0] TYPE_BACKSPACE = 8'h62;
   localparam logic [7:0] TYPE_FORMFEED  = 8'h66;
   localparam logic [7:0] TYPE_NEWLINE   = 8'h6E;
   localparam logic [7:0] TYPE_RETURN    = 8'h72;
   localparam logic [7:0] TYPE_TAB       = 8'h74;

   // named escape types
   localparam logic [7:0] TYPE_NBSP      = 8'h5F;
   localparam logic [7:0] TYPE_NULL      = 8'h30;
   localparam logic [7:0] TYPE_BELL      = 8'h61;
   localparam logic [7:0] TYPE_ESCAPE    = 8'h65;
   localparam logic [7:0] TYPE_VTAB      = 8'h76;
   localparam logic [7:0] TYPE_LINE_SEP  = 8'h4C;
   localparam logic [7:0] TYPE_NEXT_LINE = 8'h4E;
   localparam logic [7:0] TYPE_PARA_SEP  = 8'h50;

   // escape types that collect raw hex characters
   localparam logic [7:0] TYPE_HEX2      = 8'h78;
   localparam logic [7:0] TYPE_HEX4      = 8'h75;
   localparam logic [7:0] TYPE_HEX8      = 8'h55;

   // collection state of the front end
   typedef enum logic [3:0] {
      PEND_IDLE = 4'b0001,
      PEND_X    = 4'b0010,
      PEND_U    = 4'b0100,
      PEND_WIDE = 4'b1000
   } pend_type;

   // kinds of output job handed from front to back
   typedef enum logic [2:0] {
      JOB_ONE  = 3'd0,   // literal byte
      JOB_TWO  = 3'd1,   // backslash then literal byte
      JOB_HEX2 = 3'd2,   // \u00 then two held chars
      JOB_HEX4 = 3'd3,   // \u then four held chars
      JOB_HEX8 = 3'd4    // two \u escapes of four held chars each
   } job_kind_type;

   typedef struct packed {
      job_kind_type    kind;
      logic [7:0]      lit;
      logic [1:0]      err;
      logic [7:0][7:0] chars;
   } job_type;

   // named escape lookup: hit flag and four hex chars, chars[0] emitted first
   function automatic logic [32:0] named_hex(input logic [7:0] b);
      logic [32:0] r;
      r = '0;
      case (b)
         TYPE_NBSP:      r = {1'b1, 8'h30, 8'h61, 8'h30, 8'h30};   // 00a0
         TYPE_NULL:      r = {1'b1, 8'h30, 8'h30, 8'h30, 8'h30};   // 0000
         TYPE_BELL:      r = {1'b1, 8'h37, 8'h30, 8'h30, 8'h30};   // 0007
         TYPE_ESCAPE:    r = {1'b1, 8'h62, 8'h31, 8'h30, 8'h30};   // 001b
         TYPE_VTAB:      r = {1'b1, 8'h62, 8'h30, 8'h30, 8'h30};   // 000b
         TYPE_LINE_SEP:  r = {1'b1, 8'h38, 8'h32, 8'h30, 8'h32};   // 2028
         TYPE_NEXT_LINE: r = {1'b1, 8'h35, 8'h38, 8'h30, 8'h30};   // 0085
         TYPE_PARA_SEP:  r = {1'b1, 8'h39, 8'h32, 8'h30, 8'h32};   // 2029
         default:        r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ design/ye2je_front.sv @@
// front end: classifies escape type bytes, collects hex chars, issues output jobs
module ye2je_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ye2je_pkg::req_type req_data,
   output logic               job_valid,
   output ye2je_pkg::job_type job
);
   import ye2je_pkg::*;

   pend_type    pend_ff, pend_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  held_ff [8];
   logic [3:0]  count_next;
   logic [3:0]  need;
   logic [32:0] named;
   logic [7:0]  b;

   assign b          = req_data.in_byte;
   assign count_next = count_ff + 4'd1;
   assign named      = named_hex(b);

   // chars needed to finish the open sequence
   always_comb begin
      case (pend_ff)
         PEND_X:    need = 4'd2;
         PEND_U:    need = 4'd4;
         PEND_WIDE: need = 4'd8;
         default:   need = 4'd0;
      endcase
   end

   // classify the transaction and build the job
   always_comb begin
      pend_in   = pend_ff;
      count_in  = count_ff;
      job_valid = 1'b0;
      job.kind  = JOB_ONE;
      job.lit   = CHAR_NUL;
      job.err   = ERR_NONE;
      for (int i = 0; i < 8; i++) begin
         job.chars[i] = (3'(i) == count_ff[2:0]) ? b : held_ff[i];
      end
      if (accept) begin
         if (pend_ff != PEND_IDLE) begin
            if (req_data.input_end) begin
               pend_in   = PEND_IDLE;
               count_in  = 4'd0;
               job_valid = 1'b1;
               job.err   = ERR_END_OF_INPUT;
            end else if (count_next == need) begin
               pend_in   = PEND_IDLE;
               count_in  = 4'd0;
               job_valid = 1'b1;
               case (pend_ff)
                  PEND_X:  job.kind = JOB_HEX2;
                  PEND_U:  job.kind = JOB_HEX4;
                  default: job.kind = JOB_HEX8;
               endcase
            end else begin
               count_in = count_next;
            end
         end else if (!req_data.input_end) begin
            case (b)
               TYPE_QUOTE, TYPE_SLASH, TYPE_SPACE: begin
                  job_valid = 1'b1;
                  job.lit   = b;
               end
               TYPE_BACKSLASH, TYPE_BACKSPACE, TYPE_FORMFEED, TYPE_NEWLINE,
               TYPE_RETURN, TYPE_TAB: begin
                  job_valid = 1'b1;
                  job.kind  = JOB_TWO;
                  job.lit   = b;
               end
               TYPE_HEX2: begin
                  pend_in  = PEND_X;
                  count_in = 4'd0;
               end
               TYPE_HEX4: begin
                  pend_in  = PEND_U;
                  count_in = 4'd0;
               end
               TYPE_HEX8: begin
                  pend_in  = PEND_WIDE;
                  count_in = 4'd0;
               end
               default: begin
                  job_valid = 1'b1;
                  if (named[32]) begin
                     job.kind = JOB_HEX4;
                     for (int i = 0; i < 4; i++) begin
                        job.chars[i] = named[i*8 +: 8];
                     end
                  end else begin
                     job.err = ERR_BAD_TYPE;
                  end
               end
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= PEND_IDLE;
         count_ff <= 4'd0;
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   // held hex chars
   always_ff @(posedge clock) begin
      if (accept && pend_ff != PEND_IDLE && !req_data.input_end) begin
         held_ff[count_ff[2:0]] <= b;
      end
   end

`ifndef SYNTHESIS
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      pend_ff == PEND_IDLE |-> count_ff == 4'd0)
      else $error("count nonzero while idle");
   a_count_below_need: assert property (@(posedge clock) disable iff (reset)
      pend_ff != PEND_IDLE |-> count_ff < need)
      else $error("collect count reached its limit without a job");
`endif

endmodule

@@ design/ye2je_queue.sv @@
// small job queue between front and back ends
module ye2je_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ye2je_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ye2je_pkg::job_type head
);
   import ye2je_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("job queue overfilled");
`endif

endmodule

@@ design/ye2je_back.sv @@
// back end: expands one queued job into result bytes, one per cycle while rsp_pop takes them
module ye2je_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  ye2je_pkg::job_type job,
   output logic               job_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ye2je_pkg::rsp_type rsp_data
);
   import ye2je_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    gen;
   logic       load;
   logic       half;
   logic [2:0] j;
   logic [1:0] p;

   assign load = !job_empty && (!out_valid_ff || rsp_pop);
   assign half = idx_ff >= 4'd6;
   assign j    = half ? 3'(idx_ff - 4'd6) : idx_ff[2:0];
   assign p    = 2'(j - 3'd2);

   // byte for the current position in the job
   always_comb begin
      gen.error_code  = job.err;
      gen.out_byte    = job.lit;
      gen.last_of_run = 1'b1;
      case (job.kind)
         JOB_ONE: begin
            gen.out_byte    = job.lit;
            gen.last_of_run = 1'b1;
         end
         JOB_TWO: begin
            gen.out_byte    = (idx_ff == 4'd0) ? CHAR_BACKSLASH : job.lit;
            gen.last_of_run = idx_ff == 4'd1;
         end
         JOB_HEX2, JOB_HEX4, JOB_HEX8: begin
            gen.last_of_run = (job.kind == JOB_HEX8) ? idx_ff == 4'd11 : idx_ff == 4'd5;
            if (j == 3'd0) begin
               gen.out_byte = CHAR_BACKSLASH;
            end else if (j == 3'd1) begin
               gen.out_byte = CHAR_LOWER_U;
            end else if (job.kind == JOB_HEX2) begin
               gen.out_byte = p[1] ? job.chars[{2'b00, p[0]}] : CHAR_ZERO;
            end else begin
               gen.out_byte = job.chars[{half, p}];
            end
         end
         default: begin
            gen.out_byte    = job.lit;
            gen.last_of_run = 1'b1;
         end
      endcase
   end

   assign job_pop = load && gen.last_of_run;

   // position counter and output register valid
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = gen.last_of_run ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= gen;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff < 4'd12)
      else $error("job position out of range");
   a_mid_job_head: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 4'd0 |-> !job_empty)
      else $error("job left the queue before its last byte");
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      load && job.err != ERR_NONE |-> gen.last_of_run && idx_ff == 4'd0)
      else $error("error job expanded to more than one byte");
`endif

endmodule

@@ design/yaml_escape_to_json_escape_top.sv @@
// Top level of the yaml to json escape converter: front end, job queue, back end.
// Throughput: one input transaction per cycle while the job queue has room;
// results leave at one byte per cycle while rsp_pop takes them; an escape type
// expands to 1 to 12 result bytes in the back end.
// Path: a job is registered in the queue, then its bytes in the output register.
// Reset: synchronous, active high; clears collect state, queue and output valid.
module yaml_escape_to_json_escape_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  ye2je_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ye2je_pkg::rsp_type rsp_data
);
   import ye2je_pkg::*;

   logic    accept;
   logic    job_valid;
   job_type job;
   logic    q_full, q_empty, q_pop;
   job_type q_head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   ye2je_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job)
   );

   ye2je_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   ye2je_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job       (q_head),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
